FILE: rtl/assert_macros.svh
// Assertion macros shared by the identifier text parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define UTP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Condition that must never be true outside reset.
`define UTP_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define UTP_ASSERT(label, clk, rst, prop)
`define UTP_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: rtl/utp_pkg.sv
// Types and constants of the identifier text parser.
`default_nettype none
package utp_pkg;

   localparam logic [5:0] B64_LEN   = 6'd22;
   localparam logic [5:0] COUNT_MAX = 6'd63;
   localparam logic [4:0] ID_BYTES  = 5'd16;
   localparam int         B64_BITS  = 132;
   localparam int         HEX_BITS  = 128;

   localparam logic [7:0] CHR_DASH   = 8'h2d;
   localparam logic [7:0] CHR_UNDER  = 8'h5f;
   localparam logic [7:0] CHR_LBRACE = 8'h7b;
   localparam logic [7:0] CHR_RBRACE = 8'h7d;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_DIGIT = 3'd1,
      PH_DASH  = 3'd2,
      PH_CLOSE = 3'd3,
      PH_DONE  = 3'd4
   } hex_phase_type;

   typedef struct packed {
      logic [7:0] chr;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic        form;
      logic [63:0] id_high;
      logic [63:0] id_low;
   } rsp_type;

   typedef struct packed {
      logic       hex_ok;
      logic [3:0] hex_val;
      logic       b64_ok;
      logic [5:0] b64_val;
   } char_class_type;

   typedef struct packed {
      logic [5:0]            char_count;
      hex_phase_type         hex_phase;
      logic [4:0]            byte_index;
      logic                  second_nibble;
      logic                  has_brace;
      logic                  hex_bad;
      logic                  b64_bad;
      logic [HEX_BITS-1:0]   hex_accum;
      logic [B64_BITS-1:0]   b64_accum;
   } state_type;

   localparam state_type STATE_RESET = '{
      char_count:    6'd0,
      hex_phase:     PH_START,
      byte_index:    5'd0,
      second_nibble: 1'b0,
      has_brace:     1'b0,
      hex_bad:       1'b0,
      b64_bad:       1'b0,
      hex_accum:     '0,
      b64_accum:     '0
   };

endpackage
`default_nettype wire

FILE: rtl/utp_char_class.sv
// Character classifier: hex digit and base64url values of one character.
`default_nettype none
module utp_char_class (
   input  wire logic [7:0]              chr,
   output utp_pkg::char_class_type      cls
);
   import utp_pkg::*;

   logic [7:0] diff_upper;
   logic [7:0] diff_lower;
   logic [7:0] diff_digit;
   logic       is_upper;
   logic       is_lower;
   logic       is_digit;

   assign is_upper   = (chr >= 8'h41) && (chr <= 8'h5a);
   assign is_lower   = (chr >= 8'h61) && (chr <= 8'h7a);
   assign is_digit   = (chr >= 8'h30) && (chr <= 8'h39);
   assign diff_upper = chr - 8'h41;
   assign diff_lower = chr - 8'h61;
   assign diff_digit = chr - 8'h30;

   always_comb begin
      cls = '0;
      priority if (is_digit) begin
         cls.hex_ok  = 1'b1;
         cls.hex_val = diff_digit[3:0];
      end else if (is_lower && (chr <= 8'h66)) begin
         cls.hex_ok  = 1'b1;
         cls.hex_val = diff_lower[3:0] + 4'd10;
      end else if (is_upper && (chr <= 8'h46)) begin
         cls.hex_ok  = 1'b1;
         cls.hex_val = diff_upper[3:0] + 4'd10;
      end else begin
         cls.hex_ok  = 1'b0;
      end

      priority if (is_upper) begin
         cls.b64_ok  = 1'b1;
         cls.b64_val = diff_upper[5:0];
      end else if (is_lower) begin
         cls.b64_ok  = 1'b1;
         cls.b64_val = diff_lower[5:0] + 6'd26;
      end else if (is_digit) begin
         cls.b64_ok  = 1'b1;
         cls.b64_val = diff_digit[5:0] + 6'd52;
      end else if (chr == CHR_DASH) begin
         cls.b64_ok  = 1'b1;
         cls.b64_val = 6'd62;
      end else if (chr == CHR_UNDER) begin
         cls.b64_ok  = 1'b1;
         cls.b64_val = 6'd63;
      end else begin
         cls.b64_ok  = 1'b0;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/utp_parse_step.sv
// One parse step: next parser state and the result for one character.
`default_nettype none
module utp_parse_step (
   input  wire utp_pkg::state_type cur,
   input  wire utp_pkg::req_type   item,
   output utp_pkg::state_type      nxt,
   output utp_pkg::rsp_type        result
);
   import utp_pkg::*;

   char_class_type cls;
   state_type      upd;
   logic [4:0]     byte_next;
   logic           take_digit;
   logic           hex_ok;

   utp_char_class u_class (
      .chr (item.chr),
      .cls (cls)
   );

   assign byte_next = cur.byte_index + 5'd1;

   always_comb begin
      upd        = cur;
      take_digit = 1'b0;

      if (cur.char_count != COUNT_MAX) begin
         upd.char_count = cur.char_count + 6'd1;
      end

      if (!cls.b64_ok) begin
         upd.b64_bad = 1'b1;
      end else if (upd.char_count <= B64_LEN) begin
         upd.b64_accum = {cur.b64_accum[B64_BITS-7:0], cls.b64_val};
      end

      // Hex side: decide whether this character is a digit to take.
      if (!cur.hex_bad) begin
         unique case (cur.hex_phase)
            PH_START: begin
               if (item.chr == CHR_LBRACE) begin
                  upd.has_brace = 1'b1;
                  upd.hex_phase = PH_DIGIT;
               end else begin
                  take_digit = 1'b1;
               end
            end
            PH_DIGIT: begin
               take_digit = 1'b1;
            end
            PH_DASH: begin
               if (item.chr == CHR_DASH) begin
                  upd.hex_phase = PH_DIGIT;
               end else begin
                  take_digit = 1'b1;
               end
            end
            PH_CLOSE: begin
               if (cur.has_brace && (item.chr == CHR_RBRACE)) begin
                  upd.hex_phase = PH_DONE;
               end else begin
                  upd.hex_bad = 1'b1;
               end
            end
            default: begin
               upd.hex_bad = 1'b1;
            end
         endcase
      end

      if (take_digit) begin
         if (!cls.hex_ok) begin
            upd.hex_bad = 1'b1;
         end else begin
            upd.hex_accum = {cur.hex_accum[HEX_BITS-5:0], cls.hex_val};
            if (!cur.second_nibble) begin
               upd.second_nibble = 1'b1;
               upd.hex_phase     = PH_DIGIT;
            end else begin
               upd.second_nibble = 1'b0;
               upd.byte_index    = byte_next;
               if (byte_next >= ID_BYTES) begin
                  upd.hex_phase = PH_CLOSE;
               end else if (!byte_next[0]) begin
                  upd.hex_phase = PH_DASH;
               end else begin
                  upd.hex_phase = PH_DIGIT;
               end
            end
         end
      end
   end

   assign hex_ok = !upd.hex_bad &&
                   (((upd.hex_phase == PH_CLOSE) && !upd.has_brace) ||
                    (upd.hex_phase == PH_DONE));

   always_comb begin
      result      = '0;
      result.form = (upd.char_count == B64_LEN);
      if (result.form) begin
         result.ok = !upd.b64_bad;
         if (result.ok) begin
            result.id_high = upd.b64_accum[129:66];
            result.id_low  = upd.b64_accum[65:2];
         end
      end else begin
         result.ok = hex_ok;
         if (result.ok) begin
            result.id_high = upd.hex_accum[127:64];
            result.id_low  = upd.hex_accum[63:0];
         end
      end
   end

   // The string ends with its last character: start over for the next one.
   assign nxt = item.is_last ? STATE_RESET : upd;

endmodule
`default_nettype wire

FILE: rtl/uuid_text_parser_unit.sv
// Top level of the streaming identifier text parser.
//
//   channel   direction  payload            transaction
//   req_      in         chr, is_last       one character of the string
//   rsp_      out        ok, form, id_*     one parsed identifier per string
//
// A character is parsed from the input register; the block accepts one
// character per cycle unless a last character is stalled. A string's result is
// registered when its last character leaves the input register. The only stall
// comes from the result register: a last character waits in the input register
// while an earlier result has not been taken. Reset is synchronous and active
// high, clears all parser state, and needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module uuid_text_parser_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire utp_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output utp_pkg::rsp_type       rsp_data
);
   import utp_pkg::*;

   // Input register: one character transaction waiting to be parsed.
   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_ff;

   // Parser state carried from character to character of one string.
   state_type state_ff;
   state_type state_in;

   // Result register: one finished identifier waiting to be taken.
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_ff;
   rsp_type   step_result;

   logic      stage_go;

   utp_parse_step u_step (
      .cur    (state_ff),
      .item   (in_ff),
      .nxt    (state_in),
      .result (step_result)
   );

   // A character that is not the last never needs the result register, so it
   // always moves on. A last character moves on once the result slot is free
   // or is being emptied in this cycle.
   assign stage_go  = in_valid_ff &&
                      (!in_ff.is_last || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || stage_go;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = (stage_go && in_ff.is_last) ||
                         (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (stage_go) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (stage_go && in_ff.is_last) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A failed parse never carries identifier bits.
   `UTP_ASSERT(a_fail_zero, clock, reset,
      (rsp_valid_ff && !rsp_ff.ok) |-> ((rsp_ff.id_high == 64'd0) && (rsp_ff.id_low == 64'd0)))
   // Once a string's last character is parsed, the next string starts clean.
   `UTP_ASSERT(a_state_clear, clock, reset,
      (stage_go && in_ff.is_last) |=> (state_ff.char_count == 6'd0))
   // The input register only holds a character back for a full result slot.
   `UTP_ASSERT(a_stall_cause, clock, reset,
      (in_valid_ff && !stage_go) |-> (rsp_valid_ff && in_ff.is_last && !rsp_ready))
   // No more than sixteen hex bytes are ever counted.
   `UTP_NEVER(a_byte_range, clock, reset, state_ff.byte_index > ID_BYTES)

endmodule
`default_nettype wire
